// ----- design/rational_arithmetic_unit_assert.svh -----
// Assertion macros used by the top-level design file.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define RAU_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define RAU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- design/rau_pkg.sv -----
package rau_pkg;

  localparam int VW      = 32;            // operand value width
  localparam int PW      = 64;            // cross product width
  localparam int CNT_W   = $clog2(PW);
  localparam int SHIFT_W = $clog2(PW) + 1;

  localparam logic [PW-1:0] MAX_POS = PW'((64'd1 << (VW - 1)) - 64'd1);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic [1:0] mul_sel;
    logic       norm;
    logic       gcd;
    logic       div_init;
    logic       div_step;
    logic       div_store;
    logic       div_sel;   // 0: numerator magnitude, 1: denominator
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic div0;
    logic gcd_done;
  } sts_t;

endpackage

// ----- design/rau_dp.sv -----
module rau_dp (
  input  logic                clk_i,
  input  rau_pkg::cmd_t       cmd_i,
  output rau_pkg::sts_t       sts_o,
  input  logic [1:0]          opcode_i,
  input  logic signed [31:0]  a_num_i,
  input  logic [30:0]         a_den_i,
  input  logic signed [31:0]  b_num_i,
  input  logic [30:0]         b_den_i,
  output logic signed [31:0]  res_num_o,
  output logic [30:0]         res_den_o,
  output logic [1:0]          status_o
);

  localparam int PW = rau_pkg::PW;
  localparam int VW = rau_pkg::VW;

  logic [1:0]         op_q;
  logic signed [32:0] an_q, bn_q, ad_q, bd_q;
  logic               div0_q;
  logic signed [32:0] an_d, bn_d, ad_d, bd_d;

  logic signed [PW-1:0] p_q [3];
  logic signed [32:0]   mx, my;
  logic signed [65:0]   prod;

  logic signed [PW-1:0] n_s, d_s;
  logic [PW-1:0]        mag_q, dm_q;
  logic                 neg_q;

  logic [PW-1:0]                ga_q, gb_q, g_q;
  logic [rau_pkg::SHIFT_W-1:0]  gk_q;
  logic                         ga_even, gb_even;

  logic [PW-1:0] dq_q;
  logic [PW:0]   rem_q, rem_t;

  logic          ovf;

  // Read numerators sign-extended and denominators zero-extended from the value width.
  assign an_d = 33'(signed'(a_num_i[VW-1:0]));
  assign bn_d = 33'(signed'(b_num_i[VW-1:0]));
  assign ad_d = {1'b0, 32'(a_den_i[VW-2:0])};
  assign bd_d = {1'b0, 32'(b_den_i[VW-2:0])};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      an_q   <= an_d;
      bn_q   <= bn_d;
      ad_q   <= ad_d;
      bd_q   <= bd_d;
      div0_q <= (ad_d == '0) || (bd_d == '0) || ((opcode_i == rau_pkg::OP_DIV) && (bn_d == '0));
    end
  end

  // One shared multiplier computes the three products one after another.
  always_comb begin
    unique case (cmd_i.mul_sel)
      2'd0: begin
        mx = an_q;
        my = (op_q == rau_pkg::OP_MUL) ? bn_q : bd_q;
      end
      2'd1: begin
        mx = bn_q;
        my = ad_q;
      end
      default: begin
        mx = ad_q;
        my = (op_q == rau_pkg::OP_DIV) ? bn_q : bd_q;
      end
    endcase
  end

  assign prod = mx * my;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      p_q[cmd_i.mul_sel] <= prod[PW-1:0];
    end
  end

  always_comb begin
    unique case (op_q)
      rau_pkg::OP_ADD: n_s = p_q[0] + p_q[1];
      rau_pkg::OP_SUB: n_s = p_q[0] - p_q[1];
      default:         n_s = p_q[0];
    endcase
    d_s = p_q[2];
  end

  assign ga_even = ~ga_q[0];
  assign gb_even = ~gb_q[0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.norm) begin
      // Fold the denominator sign into the numerator.
      mag_q <= n_s[PW-1] ? PW'(-n_s) : PW'(n_s);
      dm_q  <= d_s[PW-1] ? PW'(-d_s) : PW'(d_s);
      neg_q <= (n_s != '0) && (n_s[PW-1] ^ d_s[PW-1]);
      ga_q  <= n_s[PW-1] ? PW'(-n_s) : PW'(n_s);
      gb_q  <= d_s[PW-1] ? PW'(-d_s) : PW'(d_s);
      gk_q  <= '0;
    end else if (cmd_i.gcd) begin
      priority if (ga_q == '0) begin
        g_q <= gb_q << gk_q;
      end else if (gb_q == '0) begin
        g_q <= ga_q << gk_q;
      end else if (ga_even && gb_even) begin
        ga_q <= ga_q >> 1;
        gb_q <= gb_q >> 1;
        gk_q <= gk_q + 1'b1;
      end else if (ga_even) begin
        ga_q <= ga_q >> 1;
      end else if (gb_even) begin
        gb_q <= gb_q >> 1;
      end else if (ga_q >= gb_q) begin
        ga_q <= (ga_q - gb_q) >> 1;
      end else begin
        gb_q <= (gb_q - ga_q) >> 1;
      end
    end else if (cmd_i.div_store) begin
      if (cmd_i.div_sel) begin
        dm_q <= dq_q;
      end else begin
        mag_q <= dq_q;
      end
    end
  end

  // Restoring divider, one quotient bit per cycle.
  assign rem_t = {rem_q[PW-1:0], dq_q[PW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dq_q  <= cmd_i.div_sel ? dm_q : mag_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_t >= {1'b0, g_q}) begin
        rem_q <= rem_t - {1'b0, g_q};
        dq_q  <= {dq_q[PW-2:0], 1'b1};
      end else begin
        rem_q <= rem_t;
        dq_q  <= {dq_q[PW-2:0], 1'b0};
      end
    end
  end

  assign ovf = (dm_q > rau_pkg::MAX_POS) ||
               (neg_q ? (mag_q > rau_pkg::MAX_POS + 1'b1) : (mag_q > rau_pkg::MAX_POS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      priority if (div0_q) begin
        res_num_o <= '0;
        res_den_o <= '0;
        status_o  <= rau_pkg::ST_DIV0;
      end else if (ovf) begin
        res_num_o <= '0;
        res_den_o <= '0;
        status_o  <= rau_pkg::ST_OVF;
      end else begin
        res_num_o <= neg_q ? -signed'(mag_q[31:0]) : signed'(mag_q[31:0]);
        res_den_o <= dm_q[30:0];
        status_o  <= rau_pkg::ST_OK;
      end
    end
  end

  assign sts_o.div0     = div0_q;
  assign sts_o.gcd_done = (ga_q == '0) || (gb_q == '0);

endmodule

// ----- design/rau_ctrl.sv -----
module rau_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rau_pkg::cmd_t cmd_o,
  input  rau_pkg::sts_t sts_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_NORM = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_DIVI = 3'd4;
  localparam logic [2:0] S_DIVS = 3'd5;
  localparam logic [2:0] S_DIVW = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]                 state_q, state_d;
  logic [rau_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                       pass_q, pass_d;
  logic                       valid_q, valid_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pass_d     = pass_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    cmd_o.mul_sel = cnt_q[1:0];
    cmd_o.div_sel = pass_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        if (sts_i.div0) begin
          state_d = S_DONE;
        end else begin
          cmd_o.mul = 1'b1;
          if (cnt_q == rau_pkg::CNT_W'(2)) begin
            cnt_d   = '0;
            state_d = S_NORM;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      S_NORM: begin
        cmd_o.norm = 1'b1;
        state_d    = S_GCD;
      end
      S_GCD: begin
        cmd_o.gcd = 1'b1;
        if (sts_i.gcd_done) begin
          pass_d  = 1'b0;
          state_d = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = S_DIVS;
      end
      S_DIVS: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          state_d = S_DIVW;
        end
      end
      S_DIVW: begin
        cmd_o.div_store = 1'b1;
        if (pass_q) begin
          state_d = S_DONE;
        end else begin
          pass_d  = 1'b1;
          state_d = S_DIVI;
        end
      end
      S_DONE: begin
        // Hold until the output register is free.
        if (!valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pass_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pass_q  <= pass_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;

endmodule

// ----- design/rational_arithmetic_unit.sv -----
// Rational add, subtract, multiply and divide with reduction to lowest terms.
// Input beat on s_axis: opcode and two operands (numerator, denominator).
// Output beat on m_axis: reduced numerator, positive denominator and status
// (ok, divide by zero, overflow); on an error both result fields are zero.
// One item is in flight at a time; s_axis_tready is high only while idle.
// From input beat to result in the output register the unit runs the cross
// multiplies, a sign fold, the binary gcd loop, two division passes (load,
// 64 restoring steps, store) and an output load; the gcd loop and the shared
// divider take most of this time. A zero denominator, or a zero divisor in a
// divide, skips from the multiply state straight to the output load.
// The next input beat is taken the cycle after the result is loaded, so a
// new item starts only once the last one has been finished.
// The output register holds a finished result while m_axis_tready is low;
// the unit takes the next input beat meanwhile and stalls only before
// writing a second result into a full output register.
// Reset clears the controller and the output valid; payload is not reset.
module rational_arithmetic_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // opcode, a_num, a_den, b_num, b_den
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata   // res_num, res_den, status, zero fill
);

  `include "rational_arithmetic_unit_assert.svh"

  rau_pkg::cmd_t      cmd;
  rau_pkg::sts_t      sts;
  logic signed [31:0] res_num;
  logic [30:0]        res_den;
  logic [1:0]         status;

  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rau_dp u_dp (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .opcode_i  (s_axis_tdata[1:0]),
    .a_num_i   (s_axis_tdata[33:2]),
    .a_den_i   (s_axis_tdata[64:34]),
    .b_num_i   (s_axis_tdata[96:65]),
    .b_den_i   (s_axis_tdata[127:97]),
    .res_num_o (res_num),
    .res_den_o (res_den),
    .status_o  (status)
  );

  assign m_axis_tdata = {7'd0, status, res_den, res_num};

  `RAU_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")
  `RAU_ASSERT_NOW(a_ok_den_nonzero, m_axis_tvalid && (m_axis_tdata[64:63] == rau_pkg::ST_OK), m_axis_tdata[62:32] != '0, "ok result with zero denominator")
  `RAU_ASSERT_NOW(a_err_zero, m_axis_tvalid && (m_axis_tdata[64:63] != rau_pkg::ST_OK), m_axis_tdata[62:0] == '0, "error result not cleared")

endmodule
